FILE: hw/rtl/cdc_pkg.sv
// Shared types and constants of the chain distance constraint block.
package cdc_pkg;
    localparam int unsigned PosW = 16;
    localparam int unsigned DirW = 16;
    localparam int unsigned LenW = 8;
    localparam int unsigned IdxW = 4;
    localparam logic signed [PosW-1:0] CentreX = 16'sd15360;
    localparam logic signed [PosW-1:0] CentreY = 16'sd8640;
    localparam logic [LenW-1:0] LinkReset = 8'd18;
    localparam logic [DirW-1:0] UnitMax = 16'd16384;

    typedef logic signed [PosW-1:0] t_pos;
    typedef logic signed [DirW-1:0] t_dir;

    typedef enum logic [3:0] {
        ST_IDLE, ST_READ, ST_LOAD, ST_SQRT, ST_DIVX, ST_DIVY, ST_PLACE, ST_OUT
    } t_state;

    // Unit-vector engine: setup, root steps, two divides, done.
    typedef enum logic [2:0] {
        U_IDLE, U_SQ, U_SQRT, U_DIVX, U_DIVY, U_FIN
    } t_uv_state;
endpackage

FILE: hw/rtl/cdc_unit_vec.sv
// Iterative square root and divider that turn a difference vector into a unit vector.
module cdc_unit_vec (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [16:0]  i_dx,
    input  logic signed [16:0]  i_dy,
    output logic                o_done,
    output cdc_pkg::t_dir       o_ux,
    output cdc_pkg::t_dir       o_uy
);
    import cdc_pkg::*;

    t_uv_state r_st, n_st;
    logic [5:0]  r_cnt;
    logic [61:0] r_rad;     // s << 28, two bits consumed per root step
    logic [33:0] r_rem;     // root remainder
    logic [30:0] r_root;    // root of s*2^28 is below 2^31
    logic [16:0] r_mx, r_my;
    logic        r_sx, r_sy;
    logic        r_zero;
    logic [30:0] r_drem;    // divide remainder, always below the root
    logic [44:0] r_num;
    logic [44:0] r_q;
    t_dir        r_ux, r_uy;

    logic [33:0] sq_x, sq_y, sq_sum;
    logic [36:0] trial;
    logic [30:0] root_nx;
    logic [31:0] dshift;
    logic [32:0] dtrial;
    logic [44:0] q_nx;
    logic [15:0] q_mag;

    assign sq_x    = r_mx * r_mx;
    assign sq_y    = r_my * r_my;
    assign sq_sum  = sq_x + sq_y;
    assign trial   = {1'b0, r_rem, r_rad[61:60]} - {4'b0, r_root, 2'b01};
    assign root_nx = {r_root[29:0], ~trial[36]};
    assign dshift  = {r_drem, r_num[44]};
    assign dtrial  = {1'b0, dshift} - {2'b0, r_root};
    assign q_nx    = {r_q[43:0], ~dtrial[32]};
    assign q_mag   = (q_nx > 45'(UnitMax)) ? UnitMax : q_nx[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= U_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            U_IDLE: if (i_start) n_st = U_SQ;
            U_SQ: n_st = U_SQRT;
            U_SQRT: if (r_cnt == 6'd1) n_st = r_zero ? U_FIN : U_DIVX;
            U_DIVX: if (r_cnt == 6'd1) n_st = U_DIVY;
            U_DIVY: if (r_cnt == 6'd1) n_st = U_FIN;
            U_FIN: n_st = U_IDLE;
            default: n_st = U_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            U_IDLE: begin
                if (i_start) begin
                    r_mx <= i_dx[16] ? 17'(-i_dx) : 17'(i_dx);
                    r_my <= i_dy[16] ? 17'(-i_dy) : 17'(i_dy);
                    r_sx <= i_dx[16];
                    r_sy <= i_dy[16];
                end
            end
            U_SQ: begin
                r_rad  <= {sq_sum, 28'd0};
                r_zero <= (sq_sum == 34'd0);
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= 6'd31;
            end
            U_SQRT: begin
                if (!trial[36]) begin
                    r_rem <= trial[33:0];
                end else begin
                    r_rem <= {r_rem[31:0], r_rad[61:60]};
                end
                r_root <= root_nx;
                r_rad  <= {r_rad[59:0], 2'b00};
                if (r_cnt == 6'd1) begin
                    // Preload the rounding offset: (m * 2^28 + root / 2) / root.
                    r_cnt  <= 6'd45;
                    r_drem <= '0;
                    r_q    <= '0;
                    r_num  <= {r_mx, 28'd0} + 45'(root_nx >> 1);
                    if (r_zero) begin
                        r_ux <= '0;
                        r_uy <= '0;
                    end
                end else begin
                    r_cnt <= r_cnt - 6'd1;
                end
            end
            U_DIVX: begin
                if (r_cnt == 6'd1) begin
                    r_ux   <= r_sx ? -q_mag : q_mag;
                    r_cnt  <= 6'd45;
                    r_drem <= '0;
                    r_q    <= '0;
                    r_num  <= {r_my, 28'd0} + 45'(r_root >> 1);
                end else begin
                    r_drem <= dtrial[32] ? dshift[30:0] : dtrial[30:0];
                    r_q    <= q_nx;
                    r_num  <= {r_num[43:0], 1'b0};
                    r_cnt  <= r_cnt - 6'd1;
                end
            end
            U_DIVY: begin
                if (r_cnt == 6'd1) begin
                    r_uy <= r_sy ? -q_mag : q_mag;
                end else begin
                    r_drem <= dtrial[32] ? dshift[30:0] : dtrial[30:0];
                    r_q    <= q_nx;
                    r_num  <= {r_num[43:0], 1'b0};
                    r_cnt  <= r_cnt - 6'd1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_done = (r_st == U_FIN);
    assign o_ux = r_ux;
    assign o_uy = r_uy;
endmodule

FILE: hw/rtl/chain_distance_constraint.sv
// Top level: chain point memory, sequencer and result register.
//  channel | dir | handshake          | payload
//  in      | in  | i_valid / o_ready  | i_head_x, i_head_y
//  out     | out | o_valid / i_ready  | o_point_index .. o_last
//  cfg     | in  | i_cfg_we           | i_cfg_data (link_length)
// Per link: read and load, engine start, the engine (setup, 31 root steps, two
// 45-step divides, done), place and output. Coincident points skip the divides.
// Reset is synchronous, active low; the chain memory is rewritten to the screen
// centre by a clearing pass over all NUM_POINTS entries after reset, during which
// no request is taken. A stalled result holds the sequencer in its output state.
module chain_distance_constraint #(
    parameter int NUM_POINTS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  cdc_pkg::t_pos  i_head_x,
    input  cdc_pkg::t_pos  i_head_y,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [3:0]     o_point_index,
    output cdc_pkg::t_pos  o_point_x,
    output cdc_pkg::t_pos  o_point_y,
    output cdc_pkg::t_dir  o_dir_x,
    output cdc_pkg::t_dir  o_dir_y,
    output logic           o_last,
    input  logic           i_cfg_we,
    input  logic [7:0]     i_cfg_data
);
    import cdc_pkg::*;

    localparam int AW = $clog2(NUM_POINTS);

    // Chain memory: one synchronous read port, one write port.
    logic [31:0] r_mem [NUM_POINTS];
    logic [31:0] r_rd;
    logic        mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [31:0] mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rd <= r_mem[mem_ra];
    end

    t_state r_st, n_st;
    logic [LenW-1:0] r_len;
    logic [AW:0] r_idx, n_idx;       // follower index / clear pointer
    logic r_clr, n_clr;
    t_pos r_px, r_py, n_px, n_py;    // predecessor (already updated)
    t_pos r_fx, r_fy;                // follower old position
    logic r_ov, n_ov;
    t_pos r_ox, r_oy;
    t_dir r_ux, r_uy;
    logic uv_start, uv_done;
    t_dir uvx, uvy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_len <= LinkReset;
        else if (i_cfg_we) r_len <= i_cfg_data;
    end

    cdc_unit_vec u_uv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(uv_start),
        .i_dx(17'(r_px) - 17'(r_fx)), .i_dy(17'(r_py) - 17'(r_fy)),
        .o_done(uv_done), .o_ux(uvx), .o_uy(uvy)
    );

    // Place: round((a+b)*8192 - u*len*16 + 8192) / 16384, saturated.
    function automatic t_pos place(input t_pos a, input t_pos b, input t_dir u,
                                   input logic [LenW-1:0] len);
        logic signed [16:0] sum;
        logic signed [24:0] ul;
        logic signed [31:0] n;
        logic signed [17:0] q;
        sum = 17'(a) + 17'(b);
        ul = 25'(u) * 25'($signed({1'b0, len}));
        n = (32'(sum) <<< 13) - (32'(ul) <<< 4) + 32'sd8192;
        q = 18'(n >>> 14);
        if (q > 18'sd32767) return 16'sh7fff;
        if (q < -18'sd32768) return 16'sh8000;
        return 16'(q);
    endfunction

    always_comb begin
        n_st = r_st; n_idx = r_idx; n_clr = r_clr; n_px = r_px; n_py = r_py; n_ov = r_ov;
        mem_we = 1'b0; mem_wa = r_idx[AW-1:0]; mem_wd = {CentreX, CentreY};
        mem_ra = r_idx[AW-1:0]; uv_start = 1'b0;
        o_ready = 1'b0;
        case (r_st)
            ST_IDLE: begin
                if (r_clr) begin
                    mem_we = 1'b1;
                    n_idx = r_idx + 1'b1;
                    if (r_idx == (AW+1)'(NUM_POINTS - 1)) n_clr = 1'b0;
                end else begin
                    o_ready = 1'b1;
                    if (i_valid) begin
                        mem_we = 1'b1; mem_wa = '0; mem_wd = {i_head_x, i_head_y};
                        n_px = i_head_x; n_py = i_head_y;
                        n_idx = (AW+1)'(1);
                        n_st = ST_READ;
                    end
                end
            end
            ST_READ: n_st = ST_LOAD;
            ST_LOAD: n_st = ST_SQRT;
            ST_SQRT: begin
                uv_start = 1'b1;
                n_st = ST_DIVX;
            end
            ST_DIVX: if (uv_done) n_st = ST_PLACE;
            ST_PLACE: begin
                mem_we = 1'b1;
                mem_wd = {place(r_px, r_fx, uvx, r_len), place(r_py, r_fy, uvy, r_len)};
                n_px = mem_wd[31:16]; n_py = mem_wd[15:0];
                n_ov = 1'b1;
                n_st = ST_OUT;
            end
            ST_OUT: if (!r_ov || i_ready) begin
                n_ov = 1'b0;
                if (r_idx == (AW+1)'(NUM_POINTS - 1)) n_st = ST_IDLE;
                else begin
                    n_idx = r_idx + 1'b1;
                    n_st = ST_READ;
                end
            end
            default: n_st = ST_IDLE;
        endcase
        if (r_ov && i_ready && r_st != ST_OUT) n_ov = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_idx <= '0; r_clr <= 1'b1; r_ov <= 1'b0;
        end else begin
            r_st <= n_st; r_idx <= n_idx; r_clr <= n_clr; r_ov <= n_ov;
        end
        r_px <= n_px; r_py <= n_py;
        if (r_st == ST_LOAD) begin
            r_fx <= t_pos'(r_rd[31:16]); r_fy <= t_pos'(r_rd[15:0]);
        end
        if (r_st == ST_PLACE) begin
            r_ox <= t_pos'(mem_wd[31:16]); r_oy <= t_pos'(mem_wd[15:0]);
            r_ux <= uvx; r_uy <= uvy;
        end
    end

    assign o_valid = r_ov;
    assign o_point_index = 4'(r_idx);
    assign o_point_x = r_ox;
    assign o_point_y = r_oy;
    assign o_dir_x = r_ux;
    assign o_dir_y = r_uy;
    assign o_last = (r_idx == (AW+1)'(NUM_POINTS - 1));
endmodule

FILE: test/chain_distance_constraint_tb.sv
// Self-checking testbench for the chain distance constraint block.
`timescale 1ns / 1ps

module chain_distance_constraint_tb;
    import cdc_pkg::*;

    localparam int NumPoints  = 16;
    localparam int Followers  = NumPoints - 1;
    localparam int ClkHalf    = 6;
    localparam int RandItems  = 200;
    localparam int SettleCyc  = 400;   // well above one link's worth of engine cycles
    localparam int HoldOffCyc = 3000;  // long receiver stall, exceeds one full request

    // One follower update as seen on the output channel.
    typedef struct {
        logic [3:0] idx;
        t_pos       px;
        t_pos       py;
        t_dir       ux;
        t_dir       uy;
        logic       last;
    } t_link_update;

    // Directed row: optional link write before it, head, and a typed-in first update.
    typedef struct {
        bit           set_link;
        logic [7:0]   link;
        t_pos         hx;
        t_pos         hy;
        bit           typed;
        t_link_update first;
    } t_head_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_pos        i_head_x;
    t_pos        i_head_y;
    logic        o_valid;
    logic        i_ready;
    logic [3:0]  o_point_index;
    t_pos        o_point_x;
    t_pos        o_point_y;
    t_dir        o_dir_x;
    t_dir        o_dir_y;
    logic        o_last;
    logic        i_cfg_we;
    logic [7:0]  i_cfg_data;

    chain_distance_constraint #(.NUM_POINTS(NumPoints)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_head_x      (i_head_x),
        .i_head_y      (i_head_y),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_point_index (o_point_index),
        .o_point_x     (o_point_x),
        .o_point_y     (o_point_y),
        .o_dir_x       (o_dir_x),
        .o_dir_y       (o_dir_y),
        .o_last        (o_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data)
    );

    // Shadow chain and link length, advanced on every accepted request.
    int           chain_x [NumPoints];
    int           chain_y [NumPoints];
    int unsigned  link_len;
    t_link_update pending_updates[$];

    int  errors;
    int  requests_sent;
    int  updates_seen;
    int  links_used;
    bit  hold_off_done;
    bit  rx_bursty;

    initial begin
        i_clk = 1'b0;
        forever #ClkHalf i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("timeout at %0t: %0d updates still pending", $time, pending_updates.size());
        $display("end of test: mismatches");
        $finish;
    end

    // Bitwise integer square root (floor).
    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitpos;
        root   = 0;
        bitpos = 64'h4000_0000_0000_0000;
        while (bitpos > v) bitpos >>= 2;
        while (bitpos != 0) begin
            if (v >= root + bitpos) begin
                v    = v - (root + bitpos);
                root = (root >> 1) + bitpos;
            end else begin
                root >>= 1;
            end
            bitpos >>= 2;
        end
        return root;
    endfunction

    // One Q2.14 component of the unit vector, rounded to nearest and clamped.
    function automatic int unit_component(longint d, longint unsigned root);
        longint unsigned mag;
        longint unsigned q;
        mag = (d < 0) ? -d : d;
        q   = ((mag << 28) + (root >> 1)) / root;
        if (q > UnitMax) q = UnitMax;
        return (d < 0) ? -int'(q) : int'(q);
    endfunction

    // New follower coordinate: midpoint minus u * link, rounded, saturated to Q12.4.
    function automatic int pull_coord(int lead, int self, int u, int unsigned len);
        longint n;
        longint q;
        n = (longint'(lead) + longint'(self)) * 8192 - longint'(u) * longint'(len) * 16 + 8192;
        q = n >>> 14;
        if (q > 32767)  q = 32767;
        if (q < -32768) q = -32768;
        return int'(q);
    endfunction

    // Move the whole shadow chain for a new head and queue the follower updates.
    task automatic drag_chain(input t_pos hx, input t_pos hy);
        longint          dx;
        longint          dy;
        longint unsigned sq;
        longint unsigned root;
        int              ux;
        int              uy;
        t_link_update    upd;
        chain_x[0] = hx;
        chain_y[0] = hy;
        for (int i = 1; i < NumPoints; i++) begin
            dx = longint'(chain_x[i-1]) - chain_x[i];
            dy = longint'(chain_y[i-1]) - chain_y[i];
            sq = dx * dx + dy * dy;
            ux = 0;
            uy = 0;
            if (sq != 0) begin
                root = floor_sqrt(sq << 28);
                ux   = unit_component(dx, root);
                uy   = unit_component(dy, root);
            end
            chain_x[i] = pull_coord(chain_x[i-1], chain_x[i], ux, link_len);
            chain_y[i] = pull_coord(chain_y[i-1], chain_y[i], uy, link_len);
            upd.idx  = i[3:0];
            upd.px   = chain_x[i][15:0];
            upd.py   = chain_y[i][15:0];
            upd.ux   = ux[15:0];
            upd.uy   = uy[15:0];
            upd.last = (i == NumPoints - 1);
            pending_updates.push_back(upd);
        end
    endtask

    // Drain every pending update, then let the sequencer settle back to idle.
    task automatic wait_drained();
        while (pending_updates.size() != 0) @(posedge i_clk);
        repeat (SettleCyc) @(posedge i_clk);
    endtask

    // Write link_length; only called while the block is idle.
    task automatic write_link(input logic [7:0] len);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= len;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        link_len    = 32'(len);
        links_used++;
    endtask

    // Offer one head request after an optional idle gap; predict on acceptance.
    task automatic send_head(input t_pos hx, input t_pos hy, input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_head_x <= hx;
        i_head_y <= hy;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        drag_chain(hx, hy);
        requests_sent++;
    endtask

    // Drop valid after the last request of a stretch.
    task automatic end_burst();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s expected %0d got %0d", $time, name, exp_v, act_v);
        end
    endtask

    // Receiver: random stall per update, one long hold-off, compare in order.
    initial begin : receiver
        t_link_update exp_u;
        int stall;
        i_ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!hold_off_done && updates_seen == 330) begin
                hold_off_done = 1'b1;
                stall = HoldOffCyc;
            end else begin
                if (updates_seen % 40 == 0) rx_bursty = $urandom_range(0, 2) == 0;
                stall = rx_bursty ? 0 : $urandom_range(0, 16);
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            updates_seen++;
            if (pending_updates.size() == 0) begin
                errors++;
                $display("%0t: unexpected update for point %0d", $time, o_point_index);
            end else begin
                exp_u = pending_updates.pop_front();
                check_field("point_index", exp_u.idx, o_point_index);
                check_field("point_x", exp_u.px, o_point_x);
                check_field("point_y", exp_u.py, o_point_y);
                check_field("dir_x", exp_u.ux, o_dir_x);
                check_field("dir_y", exp_u.uy, o_dir_y);
                check_field("last", exp_u.last, o_last);
            end
        end
    end

    // Sender: reset, directed rows, then random phases at several link lengths.
    initial begin : sender
        t_head_row rows[$];
        t_head_row r;
        t_pos      hx;
        t_pos      hy;
        int        nx;
        int        ny;
        int        span;
        int        pick;
        int        tx_gap;
        bit        tx_bursty;
        logic [7:0] phase_link [5];

        errors = 0;
        requests_sent = 0;
        updates_seen = 0;
        links_used = 0;
        hold_off_done = 1'b0;
        rx_bursty = 1'b0;
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_head_x   <= '0;
        i_head_y   <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= '0;
        for (int i = 0; i < NumPoints; i++) begin
            chain_x[i] = CentreX;
            chain_y[i] = CentreY;
        end
        link_len = LinkReset;

        // Head at the centre right after reset: every link coincident, nothing moves.
        rows.push_back('{0, 0, CentreX, CentreY, 1, '{4'd1, CentreX, CentreY, 0, 0, 0}});
        // Head 100 px to the right: point 1 goes to the midpoint less 18 px along +x.
        rows.push_back('{0, 0, 16'sd16960, CentreY, 1,
                         '{4'd1, 16'sd15872, CentreY, 16'sd16384, 0, 0}});
        rows.push_back('{0, 0, 16'sd32767, 16'sd32767, 0, '{default: 0}});
        rows.push_back('{0, 0, -16'sd32768, -16'sd32768, 0, '{default: 0}});
        rows.push_back('{0, 0, 16'sd32767, -16'sd32768, 0, '{default: 0}});
        rows.push_back('{0, 0, -16'sd32768, 16'sd32767, 0, '{default: 0}});
        // Longest link: drive positions into saturation.
        rows.push_back('{1, 8'd255, 16'sd0, 16'sd0, 0, '{default: 0}});
        rows.push_back('{0, 0, -16'sd32768, 16'sd0, 0, '{default: 0}});
        rows.push_back('{0, 0, 16'sd32767, 16'sd32767, 0, '{default: 0}});
        rows.push_back('{0, 0, -16'sd32768, -16'sd32768, 0, '{default: 0}});
        // Zero link: repeated head collapses the chain onto coincident points.
        rows.push_back('{1, 8'd0, 16'sd100, 16'sd100, 0, '{default: 0}});
        for (int i = 0; i < 6; i++)
            rows.push_back('{0, 0, 16'sd100, 16'sd100, 0, '{default: 0}});
        rows.push_back('{1, 8'd1, -16'sd1, -16'sd1, 0, '{default: 0}});
        rows.push_back('{0, 0, 16'sd0, 16'sd1, 0, '{default: 0}});

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[k]) begin
            r = rows[k];
            if (r.set_link) begin
                end_burst();
                write_link(r.link);
            end
            send_head(r.hx, r.hy, $urandom_range(0, 4));
            // Replace the predicted point-1 update with the typed-in one.
            if (r.typed) pending_updates[pending_updates.size() - Followers] = r.first;
        end
        end_burst();

        phase_link[0] = LinkReset;
        phase_link[1] = 8'd255;
        phase_link[2] = 8'($urandom_range(1, 254));
        phase_link[3] = 8'd0;
        phase_link[4] = 8'($urandom_range(1, 64));
        tx_bursty = 1'b0;
        for (int p = 0; p < 5; p++) begin
            write_link(phase_link[p]);
            for (int n = 0; n < RandItems / 5; n++) begin
                // Pause until the chain has fully drained once mid-run.
                if (p == 2 && n == 10) begin
                    end_burst();
                    while (pending_updates.size() != 0) @(posedge i_clk);
                end
                if (n % 12 == 0) tx_bursty = $urandom_range(0, 2) == 0;
                tx_gap = tx_bursty ? 0 : $urandom_range(0, 16);
                pick = $urandom_range(0, 99);
                span = (link_len + 4) * 48;
                if (pick < 12) begin
                    hx = 16'($urandom);
                    hy = 16'($urandom);
                end else if (pick < 18) begin
                    hx = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
                    hy = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
                end else if (pick < 24) begin
                    hx = 16'(chain_x[0]);
                    hy = 16'(chain_y[0]);
                end else begin
                    // Typical animation step: small move of the head.
                    nx = chain_x[0] + $urandom_range(0, 2 * span) - span;
                    ny = chain_y[0] + $urandom_range(0, 2 * span) - span;
                    hx = 16'((nx > 32767) ? 32767 : (nx < -32768) ? -32768 : nx);
                    hy = 16'((ny > 32767) ? 32767 : (ny < -32768) ? -32768 : ny);
                end
                send_head(hx, hy, tx_gap);
            end
            end_burst();
        end

        while (pending_updates.size() != 0) @(posedge i_clk);
        repeat (SettleCyc) @(posedge i_clk);
        $display("covered %0d head requests, %0d follower updates, %0d link writes",
                 requests_sent, updates_seen, links_used);
        $display("link lengths 0, 18, 255 and random; extremes, saturation, coincidence");
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
